>>> sv/blf_pkg.sv
package blf_pkg;

	localparam int P_WORDS = 18;
	localparam int SBOX_WORDS = 1024;
	localparam int BOXES = 4;
	localparam int BOX_WORDS = SBOX_WORDS / BOXES;
	localparam int ROUNDS = 16;
	localparam int QUEUE_DEPTH = 2;

	localparam int P_AW = $clog2(P_WORDS);
	localparam int S_AW = $clog2(SBOX_WORDS);
	localparam int BOX_AW = $clog2(BOX_WORDS);
	localparam int RND_W = $clog2(ROUNDS);

	typedef logic [31:0] word_t;

	typedef enum logic [1:0] {
		OP_LOAD_P  = 2'd0,
		OP_LOAD_S  = 2'd1,
		OP_EXPAND  = 2'd2,
		OP_DECRYPT = 2'd3
	} op_t;

	typedef enum logic {
		RES_BLOCK  = 1'b0,
		RES_EXPAND = 1'b1
	} res_kind_t;

	typedef struct packed {
		op_t              op;
		logic [S_AW-1:0]  index;
		word_t            a;
		word_t            b;
	} cmd_t;

	typedef struct packed {
		logic   valid;
		cmd_t   cmd;
	} cmd_chan_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PXOR,
		ST_RND_A,
		ST_RND_B,
		ST_FIN,
		ST_SWR1,
		ST_DONE
	} state_t;

endpackage

>>> sv/blf_front.sv
module blf_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               in_kind,
	input  logic [blf_pkg::S_AW-1:0] in_index,
	input  blf_pkg::word_t           in_value,
	input  blf_pkg::word_t           in_left,
	input  blf_pkg::word_t           in_right,
	output blf_pkg::cmd_chan_t       head,
	input  logic                     pop
);

	localparam int QPW = $clog2(blf_pkg::QUEUE_DEPTH);

	blf_pkg::cmd_t      q_q [blf_pkg::QUEUE_DEPTH];
	logic [QPW-1:0]     wp_q;
	logic [QPW-1:0]     rp_q;
	logic [QPW:0]       cnt_q;
	blf_pkg::cmd_t      cmd_in;
	logic               accept;
	logic               push;
	logic               drop;

	always_comb begin
		cmd_in.op = blf_pkg::op_t'(in_kind);
		cmd_in.index = in_index;
		cmd_in.a = (cmd_in.op == blf_pkg::OP_DECRYPT) ? in_left : in_value;
		cmd_in.b = in_right;
	end

	// Loads into P beyond its last entry are discarded here.
	assign drop = (cmd_in.op == blf_pkg::OP_LOAD_P) &&
		(in_index >= blf_pkg::S_AW'(blf_pkg::P_WORDS));
	assign in_ready = (cnt_q != (QPW+1)'(blf_pkg::QUEUE_DEPTH));
	assign accept = in_valid && in_ready;
	assign push = accept && !drop;

	assign head.valid = (cnt_q != '0);
	assign head.cmd = q_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wp_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (QPW+1)'(push) - (QPW+1)'(pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) pop |-> cnt_q != '0)
		else $error("queue popped while empty");
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue count lost a push");

endmodule

>>> sv/blf_back.sv
module blf_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  blf_pkg::word_t [3:0]      key,
	input  blf_pkg::cmd_chan_t        head,
	output logic                      pop,
	output logic                      res_valid,
	input  logic                      res_ready,
	output blf_pkg::res_kind_t        res_kind,
	output blf_pkg::word_t            res_left,
	output blf_pkg::word_t            res_right
);

	blf_pkg::state_t            state_q;
	blf_pkg::state_t            state_d;
	blf_pkg::word_t             p_q [blf_pkg::P_WORDS];
	blf_pkg::word_t             l_q;
	blf_pkg::word_t             r_q;
	logic [blf_pkg::RND_W-1:0]  rnd_q;
	logic [blf_pkg::P_AW-1:0]   pi_q;
	logic [blf_pkg::S_AW-1:0]   si_q;
	logic                       sph_q;
	logic                       dec_q;
	logic                       out_valid_q;
	blf_pkg::res_kind_t         out_kind_q;
	blf_pkg::word_t             out_left_q;
	blf_pkg::word_t             out_right_q;

	logic                       out_free;
	logic                       out_load;
	blf_pkg::res_kind_t         out_kind_d;
	logic [blf_pkg::P_AW-1:0]   pidx;
	blf_pkg::word_t             x;
	blf_pkg::word_t             f;
	blf_pkg::word_t             fl;
	blf_pkg::word_t             fr;
	blf_pkg::word_t             rd [blf_pkg::BOXES];
	logic                       s_we;
	logic [blf_pkg::S_AW-1:0]   s_waddr;
	blf_pkg::word_t             s_wdata;
	logic                       last_rnd;

	assign out_free = !out_valid_q || res_ready;
	assign last_rnd = (rnd_q == blf_pkg::RND_W'(blf_pkg::ROUNDS - 1));
	assign pidx = dec_q ? blf_pkg::P_AW'(blf_pkg::P_WORDS - 1) - blf_pkg::P_AW'(rnd_q)
		: blf_pkg::P_AW'(rnd_q);
	assign x = l_q ^ p_q[pidx];
	assign f = ((rd[0] + rd[1]) ^ rd[2]) + rd[3];
	assign fl = r_q ^ (dec_q ? p_q[0] : p_q[blf_pkg::P_WORDS-1]);
	assign fr = l_q ^ (dec_q ? p_q[1] : p_q[blf_pkg::P_WORDS-2]);

	for (genvar k = 0; k < blf_pkg::BOXES; k++) begin : g_box
		blf_pkg::word_t mem [blf_pkg::BOX_WORDS];
		blf_pkg::word_t rd_q;
		always_ff @(posedge clk) begin
			if (s_we && s_waddr[blf_pkg::S_AW-1 -: 2] == 2'(k)) begin
				mem[s_waddr[blf_pkg::BOX_AW-1:0]] <= s_wdata;
			end
			rd_q <= mem[x[8*(blf_pkg::BOXES-1-k) +: 8]];
		end
		assign rd[k] = rd_q;
	end

	always_comb begin
		state_d = state_q;
		pop = 1'b0;
		out_load = 1'b0;
		out_kind_d = blf_pkg::RES_BLOCK;
		s_we = 1'b0;
		s_waddr = si_q;
		s_wdata = fl;
		unique case (state_q)
			blf_pkg::ST_IDLE: begin
				if (head.valid) begin
					pop = 1'b1;
					unique case (head.cmd.op)
						blf_pkg::OP_LOAD_P: ;
						blf_pkg::OP_LOAD_S: begin
							s_we = 1'b1;
							s_waddr = head.cmd.index;
							s_wdata = head.cmd.a;
						end
						blf_pkg::OP_EXPAND: state_d = blf_pkg::ST_PXOR;
						blf_pkg::OP_DECRYPT: state_d = blf_pkg::ST_RND_A;
						default: ;
					endcase
				end
			end
			blf_pkg::ST_PXOR: begin
				if (pi_q == blf_pkg::P_AW'(blf_pkg::P_WORDS - 1)) begin
					state_d = blf_pkg::ST_RND_A;
				end
			end
			blf_pkg::ST_RND_A: state_d = blf_pkg::ST_RND_B;
			blf_pkg::ST_RND_B: state_d = last_rnd ? blf_pkg::ST_FIN : blf_pkg::ST_RND_A;
			blf_pkg::ST_FIN: begin
				if (dec_q) begin
					if (out_free) begin
						out_load = 1'b1;
						state_d = blf_pkg::ST_IDLE;
					end
				end else if (!sph_q) begin
					state_d = blf_pkg::ST_RND_A;
				end else begin
					s_we = 1'b1;
					state_d = blf_pkg::ST_SWR1;
				end
			end
			blf_pkg::ST_SWR1: begin
				s_we = 1'b1;
				s_waddr = {si_q[blf_pkg::S_AW-1:1], 1'b1};
				s_wdata = r_q;
				state_d = (si_q == blf_pkg::S_AW'(blf_pkg::SBOX_WORDS - 2)) ?
					blf_pkg::ST_DONE : blf_pkg::ST_RND_A;
			end
			blf_pkg::ST_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					out_kind_d = blf_pkg::RES_EXPAND;
					state_d = blf_pkg::ST_IDLE;
				end
			end
			default: state_d = blf_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= blf_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_kind_q <= out_kind_d;
			out_left_q <= (out_kind_d == blf_pkg::RES_EXPAND) ? '0 : fl;
			out_right_q <= (out_kind_d == blf_pkg::RES_EXPAND) ? '0 : fr;
		end
		unique case (state_q)
			blf_pkg::ST_IDLE: begin
				if (head.valid) begin
					unique case (head.cmd.op)
						blf_pkg::OP_LOAD_P: p_q[head.cmd.index[blf_pkg::P_AW-1:0]] <= head.cmd.a;
						blf_pkg::OP_LOAD_S: ;
						blf_pkg::OP_EXPAND: begin
							pi_q <= '0;
							dec_q <= 1'b0;
							sph_q <= 1'b0;
						end
						blf_pkg::OP_DECRYPT: begin
							l_q <= head.cmd.a;
							r_q <= head.cmd.b;
							dec_q <= 1'b1;
							rnd_q <= '0;
						end
						default: ;
					endcase
				end
			end
			blf_pkg::ST_PXOR: begin
				p_q[pi_q] <= p_q[pi_q] ^ key[pi_q[1:0]];
				pi_q <= pi_q + 1'b1;
				if (pi_q == blf_pkg::P_AW'(blf_pkg::P_WORDS - 1)) begin
					pi_q <= '0;
					l_q <= '0;
					r_q <= '0;
					rnd_q <= '0;
				end
			end
			blf_pkg::ST_RND_A: l_q <= x;
			blf_pkg::ST_RND_B: begin
				l_q <= r_q ^ f;
				r_q <= l_q;
				rnd_q <= rnd_q + 1'b1;
			end
			blf_pkg::ST_FIN: begin
				if (!dec_q) begin
					l_q <= fl;
					r_q <= fr;
					if (!sph_q) begin
						p_q[pi_q] <= fl;
						p_q[blf_pkg::P_AW'(pi_q + 1'b1)] <= fr;
						pi_q <= pi_q + blf_pkg::P_AW'(2);
						if (pi_q == blf_pkg::P_AW'(blf_pkg::P_WORDS - 2)) begin
							sph_q <= 1'b1;
							si_q <= '0;
						end
					end
				end
			end
			blf_pkg::ST_SWR1: si_q <= si_q + blf_pkg::S_AW'(2);
			blf_pkg::ST_DONE: ;
			default: ;
		endcase
	end

	assign res_valid = out_valid_q;
	assign res_kind = out_kind_q;
	assign res_left = out_left_q;
	assign res_right = out_right_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		s_we |-> (state_q == blf_pkg::ST_IDLE || state_q == blf_pkg::ST_FIN ||
		state_q == blf_pkg::ST_SWR1))
		else $error("S-box written during a round");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || res_ready))
		else $error("result register overwritten");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == blf_pkg::ST_RND_B && last_rnd) |=> state_q == blf_pkg::ST_FIN)
		else $error("block did not finish after the last round");
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (state_q == blf_pkg::ST_IDLE && head.valid))
		else $error("command taken while busy");

endmodule

>>> sv/blowfish_block_decrypter.sv
// Blowfish engine with externally loaded tables. A P or S-box load item is applied as it
// is taken from the queue. A decrypt item is taken from the queue, then each of the
// sixteen rounds has a state that reads the four 256-word S-box memories (registered
// read) and a state that combines them, followed by the output whitening. An expand
// item mixes the key into all 18 P entries, then runs 9 chained encryptions that
// rewrite P and 512 that rewrite the S-boxes, each of the latter needing an extra
// state because the S-box memories have one write port.
// A two-item queue sits between input and engine, and the result sits in its own register.
module blowfish_block_decrypter (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_axis_tvalid,
	output logic           s_axis_tready,
	// table_index [9:0], table_value [41:10], cipher_left [73:42], cipher_right [105:74]
	input  logic [111:0]   s_axis_tdata,
	// kind [1:0]
	input  logic [1:0]     s_axis_tuser,
	output logic           m_axis_tvalid,
	input  logic           m_axis_tready,
	// plain_left [31:0], plain_right [63:32]
	output logic [63:0]    m_axis_tdata,
	// result_kind [0]
	output logic           m_axis_tuser,
	input  logic           cfg_we,
	input  logic [1:0]     cfg_index,
	input  logic [31:0]    cfg_wdata
);

	blf_pkg::word_t [3:0]   key_q;
	blf_pkg::cmd_chan_t     head;
	logic                   pop;
	blf_pkg::res_kind_t     res_kind;
	blf_pkg::word_t         res_left;
	blf_pkg::word_t         res_right;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_we) begin
			key_q[cfg_index] <= cfg_wdata;
		end
	end

	blf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_kind  (s_axis_tuser),
		.in_index (s_axis_tdata[9:0]),
		.in_value (s_axis_tdata[41:10]),
		.in_left  (s_axis_tdata[73:42]),
		.in_right (s_axis_tdata[105:74]),
		.head     (head),
		.pop      (pop)
	);

	blf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.key       (key_q),
		.head      (head),
		.pop       (pop),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res_kind  (res_kind),
		.res_left  (res_left),
		.res_right (res_right)
	);

	assign m_axis_tdata = {res_right, res_left};
	assign m_axis_tuser = res_kind;

endmodule

>>> tb/blowfish_block_decrypter_test.sv
module blowfish_block_decrypter_test;

	localparam int LIMIT_CYCLES = 40000000;
	localparam int SETTLE_CYCLES = 80;
	localparam int HOLD_CYCLES = 400;

	typedef struct {
		blf_pkg::res_kind_t kind;
		blf_pkg::word_t     left;
		blf_pkg::word_t     right;
	} plain_item_t;

	class blowfish_scoreboard;
		blf_pkg::word_t p_words[blf_pkg::P_WORDS];
		blf_pkg::word_t s_words[blf_pkg::SBOX_WORDS];
		blf_pkg::word_t key_words[4];
		plain_item_t    awaited[$];
		int             errors;

		function new();
			foreach (p_words[i]) p_words[i] = '0;
			foreach (s_words[i]) s_words[i] = '0;
			foreach (key_words[i]) key_words[i] = '0;
			errors = 0;
		endfunction

		function blf_pkg::word_t mix(blf_pkg::word_t x);
			return ((s_words[{2'd0, x[31:24]}] + s_words[{2'd1, x[23:16]}])
				^ s_words[{2'd2, x[15:8]}]) + s_words[{2'd3, x[7:0]}];
		endfunction

		function void encipher(inout blf_pkg::word_t l, inout blf_pkg::word_t r);
			blf_pkg::word_t t;
			for (int i = 0; i < blf_pkg::ROUNDS; i++) begin
				l ^= p_words[i];
				r ^= mix(l);
				t = l; l = r; r = t;
			end
			t = l; l = r; r = t;
			r ^= p_words[16];
			l ^= p_words[17];
		endfunction

		function void decipher(inout blf_pkg::word_t l, inout blf_pkg::word_t r);
			blf_pkg::word_t t;
			for (int i = 17; i >= 2; i--) begin
				l ^= p_words[i];
				r ^= mix(l);
				t = l; l = r; r = t;
			end
			t = l; l = r; r = t;
			r ^= p_words[1];
			l ^= p_words[0];
		endfunction

		function void schedule_keys();
			blf_pkg::word_t l, r;
			l = '0;
			r = '0;
			for (int i = 0; i < blf_pkg::P_WORDS; i++) p_words[i] ^= key_words[i % 4];
			for (int i = 0; i + 1 < blf_pkg::P_WORDS; i += 2) begin
				encipher(l, r);
				p_words[i] = l;
				p_words[i + 1] = r;
			end
			for (int i = 0; i + 1 < blf_pkg::SBOX_WORDS; i += 2) begin
				encipher(l, r);
				s_words[i] = l;
				s_words[i + 1] = r;
			end
		endfunction

		function void note_item(blf_pkg::op_t op, logic [9:0] idx, blf_pkg::word_t value,
			blf_pkg::word_t l, blf_pkg::word_t r);
			plain_item_t res;
			case (op)
				blf_pkg::OP_LOAD_P: begin
					if (idx < blf_pkg::P_WORDS) p_words[idx] = value;
				end
				blf_pkg::OP_LOAD_S: begin
					s_words[idx] = value;
				end
				blf_pkg::OP_EXPAND: begin
					schedule_keys();
					res.kind = blf_pkg::RES_EXPAND;
					res.left = '0;
					res.right = '0;
					awaited.push_back(res);
				end
				default: begin
					decipher(l, r);
					res.kind = blf_pkg::RES_BLOCK;
					res.left = l;
					res.right = r;
					awaited.push_back(res);
				end
			endcase
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		task check_result(logic kind, blf_pkg::word_t l, blf_pkg::word_t r);
			plain_item_t res;
			if (awaited.size() == 0) begin
				report($sformatf("unexpected result kind %0d %h %h", kind, l, r));
				return;
			end
			res = awaited.pop_front();
			if (kind !== res.kind)
				report($sformatf("result_kind %0d, expected %0d", kind, res.kind));
			if (l !== res.left)
				report($sformatf("plain_left %h, expected %h", l, res.left));
			if (r !== res.right)
				report($sformatf("plain_right %h, expected %h", r, res.right));
		endtask
	endclass

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [111:0] s_axis_tdata = '0;
	logic [1:0]   s_axis_tuser = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [63:0]  m_axis_tdata;
	logic         m_axis_tuser;
	logic         cfg_we = 1'b0;
	logic [1:0]   cfg_index = '0;
	logic [31:0]  cfg_wdata = '0;

	blowfish_scoreboard plain_board = new();
	int send_idle_pct = 15;
	int recv_idle_pct = 56;
	int hold_requests = 0;
	int hold_served = 0;
	int cycles = 0;

	blowfish_block_decrypter u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			plain_board.note_item(blf_pkg::op_t'(s_axis_tuser), s_axis_tdata[9:0],
				s_axis_tdata[41:10], s_axis_tdata[73:42], s_axis_tdata[105:74]);
		if (arst_n && m_axis_tvalid && m_axis_tready)
			plain_board.check_result(m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[63:32]);
	end

	// The receiver stalls at random; a hold request keeps it stalled for a long stretch.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_served != hold_requests) begin
				hold_served++;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			m_axis_tready <= arst_n && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic send_item(blf_pkg::op_t op, logic [9:0] idx, blf_pkg::word_t value,
		blf_pkg::word_t l, blf_pkg::word_t r);
		if ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {6'd0, r, l, value, idx};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (plain_board.awaited.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_keys(blf_pkg::word_t k0, blf_pkg::word_t k1, blf_pkg::word_t k2,
		blf_pkg::word_t k3);
		blf_pkg::word_t keys[4];
		keys = '{k0, k1, k2, k3};
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= i[1:0];
			cfg_wdata <= keys[i];
			plain_board.key_words[i] = keys[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic random_item();
		int pick;
		pick = $urandom_range(99);
		if (pick < 72)
			send_item(blf_pkg::OP_DECRYPT, 10'($urandom), $urandom, $urandom, $urandom);
		else if (pick < 86)
			send_item(blf_pkg::OP_LOAD_P, 10'($urandom_range(blf_pkg::P_WORDS + 2)),
				$urandom, $urandom, $urandom);
		else if (pick < 99)
			send_item(blf_pkg::OP_LOAD_S, 10'($urandom), $urandom, $urandom, $urandom);
		else
			send_item(blf_pkg::OP_EXPAND, 10'($urandom), $urandom, $urandom, $urandom);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every table entry is written before anything reads the tables.
		for (int i = 0; i < blf_pkg::P_WORDS; i++)
			send_item(blf_pkg::OP_LOAD_P, 10'(i), (i == 0) ? 32'h0 : (i == 17) ? '1 : $urandom,
				$urandom, $urandom);
		for (int i = 0; i < blf_pkg::SBOX_WORDS; i++)
			send_item(blf_pkg::OP_LOAD_S, 10'(i), (i == 0) ? '1 : (i == 1023) ? 32'h0 : $urandom,
				$urandom, $urandom);

		send_item(blf_pkg::OP_DECRYPT, '0, '0, 32'h0, 32'h0);
		send_item(blf_pkg::OP_DECRYPT, '1, '1, '1, '1);
		send_item(blf_pkg::OP_DECRYPT, '0, '0, '1, 32'h0);
		send_item(blf_pkg::OP_LOAD_P, 10'd18, 32'hDEAD_BEEF, '0, '0);
		send_item(blf_pkg::OP_LOAD_P, 10'd1023, '1, '0, '0);
		send_item(blf_pkg::OP_DECRYPT, '0, '0, 32'h0, '1);
		send_item(blf_pkg::OP_LOAD_P, 10'd17, 32'h0, '1, '1);
		send_item(blf_pkg::OP_LOAD_S, 10'd1023, '1, '0, '0);
		send_item(blf_pkg::OP_LOAD_S, 10'd0, 32'h0, '0, '0);
		send_item(blf_pkg::OP_EXPAND, '1, '1, '1, '1);
		send_item(blf_pkg::OP_DECRYPT, '0, '0, 32'h0123_4567, 32'h89AB_CDEF);
		send_item(blf_pkg::OP_EXPAND, '0, '0, '0, '0);
		send_item(blf_pkg::OP_DECRYPT, '0, '0, '1, '1);

		for (int phase = 0; phase < 3; phase++) begin
			drain();
			send_idle_pct = (phase == 0) ? 15 : (phase == 1) ? 56 : 0;
			recv_idle_pct = (phase == 0) ? 56 : (phase == 1) ? 15 : 0;
			case (phase)
				0: write_keys('1, '1, '1, '1);
				1: write_keys($urandom, $urandom, $urandom, $urandom);
				default: write_keys(32'hAAAA_AAAA, 32'h5555_5555, 32'h0, '1);
			endcase
			send_item(blf_pkg::OP_EXPAND, '0, '0, '0, '0);
			for (int n = 0; n < 165; n++) begin
				if (phase == 0 && n == 40)
					hold_requests++;
				if (phase == 1 && n == 80)
					drain();
				random_item();
			end
		end

		drain();
		write_keys('0, '0, '0, '0);
		send_item(blf_pkg::OP_EXPAND, '0, '0, '0, '0);
		for (int n = 0; n < 10; n++) random_item();
		drain();

		if (plain_board.errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule
